// ===== rtl/isotp_pkg.sv =====
// ----------------------------------------------------------------------------
// isotp_pkg: shared types and constants of the ISO-TP receive reassembler
// Result kinds, error codes, protocol control codes and the result job record.
// ----------------------------------------------------------------------------
package isotp_pkg;

  localparam int unsigned ID_W     = 11;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned REG_IDX_W = 1;

  // register indexes of the configuration port
  localparam logic [REG_IDX_W-1:0] REG_RECEIVE_ID      = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FLOW_CONTROL_ID = 1'b1;

  // protocol control information: upper nibble of byte 0
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  localparam logic [7:0] FF_ESCAPE   = 8'h10;
  localparam logic [3:0] SF_MAX_LEN  = 4'd7;
  localparam logic [2:0] FF_BYTES    = 3'd6;  // payload bytes of a plain first frame
  localparam logic [2:0] FF_ESC_BYTES = 3'd2; // payload bytes of an escaped first frame
  localparam logic [2:0] CF_BYTES    = 3'd7;
  localparam logic [3:0] SEQ_START   = 4'd1;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_FC   = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_TIMEOUT = 3'd0,
    ERR_SF_LEN  = 3'd1,
    ERR_TYPE    = 3'd2,
    ERR_ZERO    = 3'd3,
    ERR_SEQ     = 3'd4
  } err_e;

  // all results caused by one input item: bytes, then flow control,
  // then completion or error
  typedef struct packed {
    logic [6:0][BYTE_W-1:0] bytes;
    logic [2:0]             n_bytes;
    logic                   fc;
    logic                   done;
    logic                   err;
    err_e                   code;
    logic [2:0]             last_idx;
  } job_t;

endpackage

// ===== rtl/isotp_if.sv =====
// ----------------------------------------------------------------------------
// isotp channel interfaces
// Valid/ready channels for received frames, result items and register writes.
// ----------------------------------------------------------------------------
interface isotp_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [isotp_pkg::ID_W-1:0]      frame_id;
  logic [isotp_pkg::BYTE_W-1:0]    data0;
  logic [isotp_pkg::BYTE_W-1:0]    data1;
  logic [isotp_pkg::BYTE_W-1:0]    data2;
  logic [isotp_pkg::BYTE_W-1:0]    data3;
  logic [isotp_pkg::BYTE_W-1:0]    data4;
  logic [isotp_pkg::BYTE_W-1:0]    data5;
  logic [isotp_pkg::BYTE_W-1:0]    data6;
  logic [isotp_pkg::BYTE_W-1:0]    data7;

  modport source (output valid, action, frame_id, data0, data1, data2, data3,
                  data4, data5, data6, data7, input ready);
  modport sink   (input valid, action, frame_id, data0, data1, data2, data3,
                  data4, data5, data6, data7, output ready);
endinterface

interface isotp_out_if;
  logic                         valid;
  logic                         ready;
  isotp_pkg::kind_e             kind;
  logic [isotp_pkg::BYTE_W-1:0] payload_byte;
  isotp_pkg::err_e              error_code;
  logic                         last;

  modport source (output valid, kind, payload_byte, error_code, last, input ready);
  modport sink   (input valid, kind, payload_byte, error_code, last, output ready);
endinterface

interface isotp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [isotp_pkg::REG_IDX_W-1:0] index;
  logic [isotp_pkg::ID_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/isotp_frame_reassembler.sv =====
// ----------------------------------------------------------------------------
// isotp_frame_reassembler: ISO-TP receive reassembler
// Decodes single, first and consecutive frames and streams payload bytes,
// flow-control requests, completion and errors as result items.
// ----------------------------------------------------------------------------
// Flow: an accepted item is held in the input register, then decoded into the
//   result register once that register is free.
// Throughput: an item holds the result register until all of its results
//   (1 to 8) are taken; items without results pass one per cycle. One item waits
//   in the input register while the result register drains.
// Reset: clears receive state (idle, sequence one), receive_id and valid flags.
module isotp_frame_reassembler (
  input  logic        clk_i,
  input  logic        rst_ni,
  isotp_in_if.sink    in_ch,
  isotp_out_if.source out_ch,
  isotp_cfg_if.sink   cfg_ch
);

  // configuration: only receive_id is stored and changes results; writes to the
  // flow-control identifier are accepted but not stored
  logic [isotp_pkg::ID_W-1:0] receive_id_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receive_id_q <= '0;
    end else if (cfg_ch.valid && cfg_ch.index == isotp_pkg::REG_RECEIVE_ID) begin
      receive_id_q <= cfg_ch.data;
    end
  end

  // input register
  logic                               s1_valid_q;
  logic                               s1_timeout_q;
  logic [isotp_pkg::ID_W-1:0]         s1_id_q;
  logic [7:0][isotp_pkg::BYTE_W-1:0]  s1_data_q;
  logic                               s1_advance;
  logic                               in_fire;

  assign in_ch.ready = !s1_valid_q || s1_advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_timeout_q <= in_ch.action;
      s1_id_q      <= in_ch.frame_id;
      s1_data_q    <= {in_ch.data7, in_ch.data6, in_ch.data5, in_ch.data4,
                       in_ch.data3, in_ch.data2, in_ch.data1, in_ch.data0};
    end
  end

  // receive state
  logic        receiving_q, receiving_d;
  logic [31:0] total_len_q, total_len_d;
  logic [31:0] rx_count_q, rx_count_d;
  logic [3:0]  exp_seq_q, exp_seq_d;

  // decode
  isotp_pkg::job_t dec_job;
  logic            dec_has;
  logic [3:0]      pci_hi, pci_nib;
  logic            escaped;
  logic [31:0]     ff_len;
  logic [2:0]      ff_n;
  logic [31:0]     remaining;
  logic [2:0]      cf_take;
  logic [3:0]      start;
  logic [3:0]      src;
  logic            go_idle;
  logic [3:0]      n_res;

  assign pci_hi    = s1_data_q[0][7:4];
  assign pci_nib   = s1_data_q[0][3:0];
  assign escaped   = (s1_data_q[0] == isotp_pkg::FF_ESCAPE) && (s1_data_q[1] == '0);
  assign ff_len    = escaped ? {s1_data_q[2], s1_data_q[3], s1_data_q[4], s1_data_q[5]}
                             : {20'd0, pci_nib, s1_data_q[1]};
  assign ff_n      = escaped ? isotp_pkg::FF_ESC_BYTES : isotp_pkg::FF_BYTES;
  assign remaining = total_len_q - rx_count_q;
  assign cf_take   = (remaining < {29'd0, isotp_pkg::CF_BYTES}) ? remaining[2:0]
                                                                 : isotp_pkg::CF_BYTES;

  always_comb begin
    dec_job     = '0;
    start       = 4'd1;
    src         = '0;
    receiving_d = receiving_q;
    total_len_d = total_len_q;
    rx_count_d  = rx_count_q;
    exp_seq_d   = exp_seq_q;

    priority if (s1_timeout_q) begin
      dec_job.err  = 1'b1;
      dec_job.code = isotp_pkg::ERR_TIMEOUT;
    end else if (s1_id_q != receive_id_q) begin
      // foreign identifier: drop
    end else if (!receiving_q) begin
      unique case (pci_hi)
        isotp_pkg::PCI_SF: begin
          if (pci_nib > isotp_pkg::SF_MAX_LEN) begin
            dec_job.err  = 1'b1;
            dec_job.code = isotp_pkg::ERR_SF_LEN;
          end else begin
            dec_job.n_bytes = pci_nib[2:0];
            dec_job.done    = 1'b1;
          end
        end
        isotp_pkg::PCI_FF: begin
          start = escaped ? 4'd6 : 4'd2;
          if (ff_len == '0) begin
            dec_job.err  = 1'b1;
            dec_job.code = isotp_pkg::ERR_ZERO;
          end else if ({29'd0, ff_n} > ff_len) begin
            dec_job.n_bytes = ff_len[2:0];
            dec_job.done    = 1'b1;
          end else begin
            dec_job.n_bytes = ff_n;
            dec_job.fc      = 1'b1;
            if ({29'd0, ff_n} == ff_len) begin
              dec_job.done = 1'b1;
            end else begin
              receiving_d = 1'b1;
              total_len_d = ff_len;
              rx_count_d  = {29'd0, ff_n};
              exp_seq_d   = isotp_pkg::SEQ_START;
            end
          end
        end
        default: begin
          dec_job.err  = 1'b1;
          dec_job.code = isotp_pkg::ERR_TYPE;
        end
      endcase
    end else if (pci_hi == isotp_pkg::PCI_CF) begin
      if (pci_nib != exp_seq_q) begin
        dec_job.err  = 1'b1;
        dec_job.code = isotp_pkg::ERR_SEQ;
      end else begin
        exp_seq_d       = exp_seq_q + 4'd1;
        dec_job.n_bytes = cf_take;
        rx_count_d      = rx_count_q + {29'd0, cf_take};
        if (remaining <= {29'd0, isotp_pkg::CF_BYTES}) begin
          dec_job.done = 1'b1;
        end
      end
    end else begin
      // other frame types while receiving: drop
    end

    // every error or completion returns to idle
    go_idle = dec_job.err || dec_job.done;
    if (go_idle) begin
      receiving_d = 1'b0;
      total_len_d = '0;
      rx_count_d  = '0;
      exp_seq_d   = isotp_pkg::SEQ_START;
    end

    // align payload bytes so that the first one sits at index zero
    for (int k = 0; k < 7; k++) begin
      src = start + 4'(k);
      dec_job.bytes[k] = src[3] ? '0 : s1_data_q[src[2:0]];
    end

    n_res = {1'b0, dec_job.n_bytes} + {3'd0, dec_job.fc} + {3'd0, go_idle};
    dec_job.last_idx = 3'(n_res - 4'd1);
  end

  assign dec_has = (n_res != '0);

  // result register and serializer
  isotp_pkg::job_t job_q;
  logic            job_valid_q;
  logic [2:0]      idx_q;
  logic            out_fire;
  logic            out_last;
  logic            job_free;
  logic            job_load;
  logic            is_byte;

  assign out_fire   = out_ch.valid && out_ch.ready;
  assign out_last   = (idx_q == job_q.last_idx);
  assign job_free   = !job_valid_q || (out_fire && out_last);
  assign s1_advance = s1_valid_q && (job_free || !dec_has);
  assign job_load   = s1_advance && dec_has;

  // advance receive state in item order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      total_len_q <= '0;
      rx_count_q  <= '0;
      exp_seq_q   <= isotp_pkg::SEQ_START;
    end else if (s1_advance) begin
      receiving_q <= receiving_d;
      total_len_q <= total_len_d;
      rx_count_q  <= rx_count_d;
      exp_seq_q   <= exp_seq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (job_load) begin
      job_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (out_fire) begin
      if (out_last) begin
        job_valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      job_q <= dec_job;
    end
  end

  // select the current result item
  assign is_byte = (idx_q < job_q.n_bytes);

  always_comb begin
    out_ch.payload_byte = '0;
    out_ch.error_code   = isotp_pkg::ERR_TIMEOUT;
    priority if (is_byte) begin
      out_ch.kind         = isotp_pkg::KIND_BYTE;
      out_ch.payload_byte = job_q.bytes[idx_q];
    end else if (job_q.err) begin
      out_ch.kind       = isotp_pkg::KIND_ERR;
      out_ch.error_code = job_q.code;
    end else if (job_q.fc && idx_q == job_q.n_bytes) begin
      out_ch.kind = isotp_pkg::KIND_FC;
    end else begin
      out_ch.kind = isotp_pkg::KIND_DONE;
    end
  end

  assign out_ch.valid = job_valid_q;
  assign out_ch.last  = out_last;

  // checks
  a_count_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    receiving_q |-> (rx_count_q < total_len_q))
    else $error("received count reached total length while receiving");

  a_idle_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !receiving_q |-> (rx_count_q == '0 && total_len_q == '0
                      && exp_seq_q == isotp_pkg::SEQ_START))
    else $error("idle state not cleared");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load |-> job_free)
    else $error("result job overwritten before its last item left");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (idx_q <= job_q.last_idx))
    else $error("result index beyond last result");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_last && !job_load) |=> !job_valid_q)
    else $error("result job stayed valid after its last item");

endmodule
